>>> rtl/vrwa_pkg.sv
`default_nettype none
package vrwa_pkg;
  localparam int SUM_W = 48;
  localparam int VAL_W = 32;
  localparam int CNT_W = 16;
  localparam int CFG_W = 11;

  typedef enum logic [1:0] {
    REG_ROWS   = 2'd0,
    REG_REPEAT = 2'd1,
    REG_MODE   = 2'd2,
    REG_WINDOW = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_LATEST  = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_WINDOW  = 2'd2
  } avg_mode_t;

  localparam logic signed [SUM_W-1:0] MAX48 = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] MIN48 = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] MAX32 = 48'sh0000_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] MIN32 = -48'sh0000_8000_0000;

  // divider control group
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> rtl/vector_repeat_window_averager_top.sv
`default_nettype none
// vector repeat window averager
// in_ channel: one sample element per transfer, tdata = sample_value (Q16.16),
// tlast = vector_end. out_ channel: one averaged row per element of the last
// vector of each block; elements of other vectors give no result.
// cfg_ port: write enable, register index (0 rows, 1 repeats, 2 mode,
// 3 window length) and data; write only while idle.
// timing: an element that yields no result passes the read and accumulate states
// before the next input transfer. one that yields a result also takes two passes
// through the shared 48-bit radix-2 divider (block value, then normalized total),
// one bit per cycle, before it is offered; the next element is taken once it has
// left the output register.
// in_tready is low while an element is worked on and while a result waits in
// the output register; a stalled receiver simply holds the block.
// reset: after rst_n a clearing pass over all MAX_ROWS rows zeroes the repeat sums
// and totals memories; in_tready stays low during it. window history is never
// cleared.
module vector_repeat_window_averager_top #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_WINDOW = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // sample_value
  input  wire logic        in_tlast,   // vector_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // row_index, averaged_value, blocks_in_use
  output logic             out_tlast,  // result_last
  output logic             out_tuser   // overflow
);
  import vrwa_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int HD = MAX_ROWS * MAX_WINDOW;
  localparam int HW = $clog2(HD) > 0 ? $clog2(HD) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_ACC, S_DIV1, S_COMB, S_DIV2, S_OUT
  } state_t;
  state_t state_r;

  logic [10:0] rows_cfg_r, reps_cfg_r;
  logic [1:0]  mode_cfg_r;
  logic [4:0]  wl_cfg_r;

  logic [RW-1:0] row_counter_r, row_r;
  logic [9:0]    repeat_counter_r;
  logic [WW-1:0] window_slot_r;
  logic          window_full_r;
  logic [CNT_W-1:0] block_count_r, norm_r;
  logic [31:0]   sample_r;
  logic          vend_r, ovf_r, last_row_r, last_rep_r;
  logic [RW:0]   clr_r;
  logic signed [SUM_W-1:0] tot_r, blk_r;

  // clamped registers
  logic [16:0] rows_c, wl_c;
  logic [10:0] reps_c;
  always_comb begin
    rows_c = 17'(rows_cfg_r);
    if (rows_c == 0) rows_c = 17'd1;
    else if (rows_c > 17'(MAX_ROWS)) rows_c = 17'(MAX_ROWS);
    reps_c = (reps_cfg_r == 0) ? 11'd1 : (reps_cfg_r > 11'd1024 ? 11'd1024 : reps_cfg_r);
    wl_c = 17'(wl_cfg_r);
    if (wl_c == 0) wl_c = 17'd1;
    else if (wl_c > 17'(MAX_WINDOW)) wl_c = 17'(MAX_WINDOW);
  end

  // memories
  logic          rs_we, ct_we, wh_we;
  logic [RW-1:0] ct_waddr;
  logic [SUM_W-1:0] rs_wdata, rs_din, ct_wdata, rs_rdata, ct_rdata;
  logic [VAL_W-1:0] wh_rdata;
  logic [WW-1:0] slot_u;
  logic [HW-1:0] wh_addr;

  assign slot_u  = (17'(window_slot_r) < wl_c) ? window_slot_r : '0;
  assign wh_addr = HW'(slot_u) * HW'(MAX_ROWS) + HW'(row_r);

  vrwa_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ROWS)) u_rsum (
    .clk, .we(rs_we), .waddr(ct_waddr), .wdata(rs_din), .raddr(row_r), .rdata(rs_rdata));
  vrwa_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ROWS)) u_tot (
    .clk, .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata), .raddr(row_r), .rdata(ct_rdata));
  vrwa_ram #(.WIDTH(VAL_W), .DEPTH(HD)) u_hist (
    .clk, .we(wh_we), .waddr(wh_addr), .wdata(blk_r[VAL_W-1:0]), .raddr(wh_addr),
    .rdata(wh_rdata));

  div_req_t dreq;
  div_rsp_t drsp;
  vrwa_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  // accumulate
  logic signed [SUM_W:0] acc;
  logic acc_ovf;
  logic signed [SUM_W-1:0] acc_sat;
  always_comb begin
    acc = $signed({rs_rdata[SUM_W-1], rs_rdata}) +
          $signed({{(SUM_W-31){sample_r[31]}}, sample_r});
    acc_ovf = (acc[SUM_W] != acc[SUM_W-1]);
    acc_sat = acc_ovf ? (acc[SUM_W] ? MIN48 : MAX48) : acc[SUM_W-1:0];
  end

  // combine: one add path, history subtract in window mode
  logic signed [SUM_W+1:0] cmb;
  logic signed [SUM_W-1:0] cmb_sat;
  logic cmb_ovf;
  always_comb begin
    cmb = 50'(signed'(blk_r));
    if (mode_cfg_r == MODE_RUNNING || mode_cfg_r == MODE_WINDOW)
      cmb = cmb + 50'(signed'(ct_rdata));
    if (mode_cfg_r == MODE_WINDOW && window_full_r)
      cmb = cmb - 50'(signed'(wh_rdata));
    cmb_ovf = (cmb > 50'(MAX48)) || (cmb < 50'(MIN48));
    cmb_sat = (cmb > 50'(MAX48)) ? MAX48 : ((cmb < 50'(MIN48)) ? MIN48 : cmb[SUM_W-1:0]);
  end

  logic signed [SUM_W-1:0] q;
  logic q_ovf;
  logic signed [SUM_W-1:0] q_sat;
  assign q     = signed'(drsp.quotient);
  assign q_ovf = (q > MAX32) || (q < MIN32);
  assign q_sat = (q > MAX32) ? MAX32 : ((q < MIN32) ? MIN32 : q);

  logic [CNT_W-1:0] norm_c;
  logic norm_ovf;
  always_comb begin
    norm_ovf = 1'b0;
    unique case (mode_cfg_r)
      MODE_RUNNING: begin
        if (block_count_r == {CNT_W{1'b1}}) begin
          norm_c = {CNT_W{1'b1}};
          norm_ovf = 1'b1;
        end else norm_c = block_count_r + 1'b1;
      end
      MODE_WINDOW: norm_c = window_full_r ? CNT_W'(wl_c) : CNT_W'(slot_u) + 1'b1;
      default: norm_c = CNT_W'(1);
    endcase
  end

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  always_comb begin
    rs_we    = (state_r == S_ACC) || (state_r == S_CLEAR);
    rs_wdata = (repeat_counter_r == 0) ? {{(SUM_W-32){sample_r[31]}}, sample_r} : acc_sat;
    rs_din   = (state_r == S_CLEAR) ? '0 : rs_wdata;
    ct_we    = (state_r == S_CLEAR) || (state_r == S_COMB);
    ct_waddr = (state_r == S_CLEAR) ? clr_r[RW-1:0] : row_r;
    ct_wdata = (state_r == S_CLEAR) ? '0 : cmb_sat;
    wh_we    = (state_r == S_COMB) && (mode_cfg_r == MODE_WINDOW);
    dreq.start    = 1'b0;
    dreq.dividend = rs_wdata;
    dreq.divisor  = CNT_W'(reps_c);
    if (state_r == S_ACC && last_rep_r) dreq.start = 1'b1;
    if (state_r == S_COMB) begin
      dreq.start    = 1'b1;
      dreq.dividend = cmb_sat;
      dreq.divisor  = norm_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_CLEAR;
      clr_r            <= '0;
      rows_cfg_r       <= 11'd1024;
      reps_cfg_r       <= 11'd1;
      mode_cfg_r       <= MODE_LATEST;
      wl_cfg_r         <= 5'd1;
      row_counter_r    <= '0;
      repeat_counter_r <= '0;
      window_slot_r    <= '0;
      window_full_r    <= 1'b0;
      block_count_r    <= '0;
      out_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_ROWS:   rows_cfg_r <= cfg_wdata;
          REG_REPEAT: reps_cfg_r <= cfg_wdata;
          REG_MODE:   mode_cfg_r <= cfg_wdata[1:0];
          REG_WINDOW: wl_cfg_r   <= cfg_wdata[4:0];
        endcase
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (RW+1)'(MAX_ROWS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_xfer) begin
          sample_r <= in_tdata;
          vend_r   <= in_tlast;
          row_r    <= row_counter_r;
          state_r  <= S_READ;
        end
        S_READ: begin
          last_row_r <= vend_r || (17'(row_r) + 17'd1 >= rows_c);
          last_rep_r <= (11'(repeat_counter_r) + 11'd1 >= reps_c);
          state_r    <= S_ACC;
        end
        S_ACC: begin
          ovf_r <= (repeat_counter_r != 0) && acc_ovf;
          if (last_row_r) begin
            row_counter_r    <= '0;
            repeat_counter_r <= last_rep_r ? 10'd0 : repeat_counter_r + 10'd1;
          end else row_counter_r <= row_r + 1'b1;
          state_r <= last_rep_r ? S_DIV1 : S_IDLE;
        end
        S_DIV1: if (drsp.done) begin
          blk_r   <= q_sat;
          ovf_r   <= ovf_r | q_ovf;
          state_r <= S_COMB;
        end
        S_COMB: begin
          norm_r <= norm_c;
          ovf_r  <= ovf_r | cmb_ovf | norm_ovf;
          if (last_row_r) begin
            block_count_r <= norm_c;
            if (mode_cfg_r == MODE_WINDOW) begin
              if (17'(slot_u) + 17'd1 >= wl_c) begin
                window_slot_r <= '0;
                window_full_r <= 1'b1;
              end else window_slot_r <= slot_u + 1'b1;
            end
          end
          state_r <= S_DIV2;
        end
        S_DIV2: if (drsp.done) begin
          out_tdata  <= {6'd0, norm_r, q_sat[31:0], 10'(row_r)};
          out_tlast  <= last_row_r;
          out_tuser  <= ovf_r | q_ovf;
          out_tvalid <= 1'b1;
          state_r    <= S_OUT;
        end
        S_OUT: if (out_tready) begin
          out_tvalid <= 1'b0;
          state_r    <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // result only leaves from the output state
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == S_OUT) else $error("result outside output state");
  // no input taken while a result waits
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input accepted while result pending");
  // divider finishes only in a division state
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == S_DIV1 || state_r == S_DIV2)) else $error("stray divider done");
endmodule
`default_nettype wire

>>> rtl/vrwa_ram.sv
`default_nettype none
module vrwa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/vrwa_div.sv
`default_nettype none
module vrwa_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  vrwa_pkg::div_req_t    req,
  output vrwa_pkg::div_rsp_t    rsp
);
  import vrwa_pkg::*;

  // signed restoring division, truncates toward zero, one quotient bit a cycle
  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] dvs_r;
  logic             neg_r;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;
  logic [SUM_W-1:0] mag, res;
  logic [SUM_W:0]   trial;

  assign mag = req.dividend[SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;

  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]} - {{(SUM_W-CNT_W+1){1'b0}}, dvs_r};
    rem_nxt = {rem_r[SUM_W-2:0], quo_r[SUM_W-1]};
    quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
    if (!trial[SUM_W]) begin
      rem_nxt    = trial[SUM_W-1:0];
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(SUM_W);
        rem_r  <= '0;
        quo_r  <= mag;
        dvs_r  <= req.divisor;
        neg_r  <= req.dividend[SUM_W-1];
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res          = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = res;
endmodule
`default_nettype wire

>>> test/vrwa_checker.sv
`timescale 1ns / 100ps
module vrwa_checker
  import vrwa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [63:0] out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        out_tuser,
  output int               fails,
  output int               pending
);
  typedef struct packed {
    logic [9:0]  row;
    logic [31:0] value;
    logic [15:0] norm;
    logic        last;
    logic        ovf;
  } row_avg_t;

  row_avg_t avg_q[$];

  logic [10:0] rows_reg, reps_reg;
  logic [1:0]  mode_reg;
  logic [4:0]  wlen_reg;
  longint      rep_sum [1024];
  longint      row_total [1024];
  longint      history [16384];
  int unsigned row_cnt, rep_cnt, slot_cnt, blk_cnt;
  bit          win_full;
  bit          sat_hit;

  function automatic longint sat(longint v, longint lo, longint hi);
    if (v > hi) begin
      sat_hit = 1;
      return hi;
    end
    if (v < lo) begin
      sat_hit = 1;
      return lo;
    end
    return v;
  endfunction

  function automatic int unsigned clampu(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic predict_sample(logic [31:0] sample, logic vend);
    int unsigned rows, reps, wl, row, slot, norm, idx;
    bit lrow, lrep;
    longint s, blk, tot, q;
    row_avg_t r;
    rows = clampu(rows_reg, 1024);
    reps = clampu(reps_reg, 1024);
    wl = clampu(wlen_reg, 16);
    row = row_cnt;
    s = longint'($signed(sample));
    sat_hit = 0;
    lrow = vend || (row + 1 >= rows);
    lrep = (rep_cnt + 1 >= reps);
    if (rep_cnt == 0) rep_sum[row] = s;
    else rep_sum[row] = sat(rep_sum[row] + s, MIN48, MAX48);
    if (lrow) begin
      row_cnt = 0;
      rep_cnt = lrep ? 0 : rep_cnt + 1;
    end else begin
      row_cnt = row + 1;
    end
    if (!lrep) return;
    blk = sat(rep_sum[row] / longint'(reps), MIN32, MAX32);
    slot = (slot_cnt < wl) ? slot_cnt : 0;
    if (mode_reg == MODE_RUNNING) begin
      tot = sat(row_total[row] + blk, MIN48, MAX48);
      if (blk_cnt >= 65535) begin
        sat_hit = 1;
        norm = 65535;
      end else begin
        norm = blk_cnt + 1;
      end
    end else if (mode_reg == MODE_WINDOW) begin
      idx = slot * 1024 + row;
      tot = row_total[row] + blk;
      if (win_full) tot -= history[idx];
      tot = sat(tot, MIN48, MAX48);
      history[idx] = blk;
      norm = win_full ? wl : slot + 1;
    end else begin
      tot = blk;
      norm = 1;
    end
    row_total[row] = tot;
    q = sat(tot / longint'(norm), MIN32, MAX32);
    if (lrow) begin
      blk_cnt = norm;
      if (mode_reg == MODE_WINDOW) begin
        slot++;
        if (slot >= wl) begin
          slot = 0;
          win_full = 1;
        end
        slot_cnt = slot;
      end
    end
    r.row = row[9:0];
    r.value = q[31:0];
    r.norm = norm[15:0];
    r.last = lrow;
    r.ovf = sat_hit;
    avg_q.push_back(r);
  endtask

  initial begin
    fails = 0;
    for (int i = 0; i < 1024; i++) begin
      rep_sum[i] = 0;
      row_total[i] = 0;
    end
    for (int i = 0; i < 16384; i++) history[i] = 0;
  end

  assign pending = avg_q.size();

  always @(posedge clk) begin
    row_avg_t e;
    if (!rst_n) begin
      rows_reg <= 11'd1024;
      reps_reg <= 11'd1;
      mode_reg <= MODE_LATEST;
      wlen_reg <= 5'd1;
      row_cnt = 0;
      rep_cnt = 0;
      slot_cnt = 0;
      blk_cnt = 0;
      win_full = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_ROWS:   rows_reg <= cfg_wdata;
          REG_REPEAT: reps_reg <= cfg_wdata;
          REG_MODE:   mode_reg <= cfg_wdata[1:0];
          REG_WINDOW: wlen_reg <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_sample(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (avg_q.size() == 0) begin
          $error("unexpected result transfer, row_index %0d", out_tdata[9:0]);
          fails++;
        end else begin
          e = avg_q.pop_front();
          if (out_tdata[9:0] !== e.row) begin
            $error("row_index expected %0d actual %0d", e.row, out_tdata[9:0]);
            fails++;
          end
          if (out_tdata[41:10] !== e.value) begin
            $error("averaged_value expected %h actual %h", e.value, out_tdata[41:10]);
            fails++;
          end
          if (out_tdata[57:42] !== e.norm) begin
            $error("blocks_in_use expected %0d actual %0d", e.norm, out_tdata[57:42]);
            fails++;
          end
          if (out_tlast !== e.last) begin
            $error("result_last expected %b actual %b", e.last, out_tlast);
            fails++;
          end
          if (out_tuser !== e.ovf) begin
            $error("overflow expected %b actual %b", e.ovf, out_tuser);
            fails++;
          end
        end
      end
    end
  end
endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
module tb;
  import vrwa_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  reg_idx_t    cfg_index;
  logic [10:0] cfg_wdata;
  logic        in_tvalid, in_tready, in_tlast;
  logic [31:0] in_tdata;
  logic        out_tvalid, out_tready, out_tlast, out_tuser;
  logic [63:0] out_tdata;
  int          fails, pending;
  logic        in_acc;
  int          send_pct, recv_pct, hold_cycles;

  vector_repeat_window_averager_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  vrwa_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // input transfer seen at the last rising edge
  always @(posedge clk) in_acc <= in_tvalid && in_tready;

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    int held;
    out_tready = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0 && held < hold_cycles) begin
        held++;
        out_tready <= 0;
      end else begin
        if (held >= hold_cycles) held = 0;
        hold_cycles = 0;
        out_tready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'($signed($urandom_range(131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sample(logic [31:0] d, logic vend);
    while ($urandom_range(99) < send_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    in_tlast <= vend;
    do @(negedge clk); while (!in_acc);
  endtask

  task automatic write_cfg(int rows, int reps, int mode, int wlen);
    int vals[4];
    vals = '{rows, reps, mode, wlen};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= reg_idx_t'(i);
      cfg_wdata <= vals[i][10:0];
      @(negedge clk);
    end
    cfg_we <= 0;
  endtask

  // one setting: drain, reprogram, then stream whole vectors until nitems are sent
  task automatic run_setting(int rows, int reps, int mode, int wlen,
                             int nitems, int minlen, int maxlen, int phase);
    int eff, len, sent;
    bit vend;
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    write_cfg(rows, reps, mode, wlen);
    case (phase % 4)
      0: begin send_pct = 0;  recv_pct = 0;  end
      1: begin send_pct = 82; recv_pct = 0;  end
      2: begin send_pct = 0;  recv_pct = 82; end
      default: begin send_pct = 37; recv_pct = 37; end
    endcase
    eff = (rows < 1) ? 1 : (rows > 1024) ? 1024 : rows;
    sent = 0;
    while (sent < nitems) begin
      len = $urandom_range(maxlen < eff ? maxlen : eff, minlen < eff ? minlen : eff);
      for (int k = 0; k < len; k++) begin
        if (k != len - 1) vend = 0;
        else if (len < eff) vend = 1;
        else vend = $urandom_range(1);
        send_sample(pick_sample(), vend);
        sent++;
      end
    end
    in_tvalid <= 0;
  endtask

  initial begin
    int rows, mode;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = REG_ROWS;
    cfg_wdata = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tlast = 0;
    send_pct = 0;
    recv_pct = 0;
    hold_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // clearing pass of the sums and totals memories
    repeat (1100) @(negedge clk);

    // directed: extremes of values and registers, mode 3, skipped rows
    run_setting(4, 1, MODE_LATEST, 1, 12, 4, 4, 0);
    run_setting(2047, 1, 3, 0, 10, 1, 6, 1);
    run_setting(3, 2, MODE_RUNNING, 31, 12, 1, 3, 2);
    run_setting(0, 0, MODE_RUNNING, 1, 24, 1, 1, 0);
    // fill every history slot for rows 0..7 before any window read
    run_setting(8, 1, MODE_WINDOW, 16, 160, 8, 8, 3);
    run_setting(8, 2, MODE_WINDOW, 31, 32, 1, 8, 1);

    for (int p = 0; p < 14; p++) begin
      mode = $urandom_range(3);
      rows = $urandom_range(8, 1);
      if (mode != MODE_WINDOW && $urandom_range(3) == 0) rows = 1024;
      if (p == 2) hold_cycles = 400;
      run_setting(rows, $urandom_range(4, 1), mode, $urandom_range(31),
                  43, 1, (rows > 8) ? 8 : rows, p);
    end

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fails == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
